@@ design/spcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted product channel sum: shared definitions
// Plane limits, store geometry, field widths and configuration register codes.
// ----------------------------------------------------------------------------
package spcs_pkg;

   // Plane and kernel limits.
   localparam int MAX_OUT_WIDTH  = 256;
   localparam int MAX_OUT_HEIGHT = 256;
   localparam int MAX_KERNEL     = 4;
   localparam int MAX_GROUPS     = 1024;

   // Sample and sum formats.
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int OUT_BITS    = 40;

   // Register field widths.
   localparam int KSIZE_BITS    = 3;
   localparam int DIM_BITS      = 9;
   localparam int GCOUNT_BITS   = 11;
   localparam int CSR_DATA_BITS = 11;

   // Counter widths.
   localparam int GRP_BITS  = $clog2(MAX_GROUPS);
   localparam int KOFF_BITS = $clog2(MAX_KERNEL);

   // Feature line store: one row per kernel row, one entry per input column.
   localparam int DL_ROW_BITS   = $clog2(MAX_KERNEL);
   localparam int DL_COL_BITS   = $clog2(MAX_OUT_WIDTH);
   localparam int DL_DEPTH      = MAX_KERNEL * MAX_OUT_WIDTH;
   localparam int DL_ADDR_BITS  = DL_ROW_BITS + DL_COL_BITS;

   // Accumulator plane: one sum per pixel of the enlarged output plane.
   localparam int ACC_ROWS      = MAX_OUT_HEIGHT + MAX_KERNEL - 1;
   localparam int ACC_COLS      = MAX_OUT_WIDTH + MAX_KERNEL - 1;
   localparam int ACC_DEPTH     = ACC_ROWS * ACC_COLS;
   localparam int ACC_ADDR_BITS = $clog2(ACC_DEPTH);

   // Register values after reset.
   localparam logic [KSIZE_BITS-1:0]  KERNEL_RESET = KSIZE_BITS'(3);
   localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = DIM_BITS'(64);
   localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = DIM_BITS'(64);
   localparam logic [GCOUNT_BITS-1:0] GROUP_RESET  = GCOUNT_BITS'(1);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_KERNEL_SIZE = 2'd0,
      REG_IN_HEIGHT   = 2'd1,
      REG_IN_WIDTH    = 2'd2,
      REG_GROUP_COUNT = 2'd3
   } csr_index_type;

endpackage

@@ design/shifted_product_channel_sum_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted product channel sum unit
// Dynamic local filter forward pass: delays each feature sample by a channel
// dependent row and column offset, multiplies it by a per-pixel weight and
// sums the products per output pixel over each group of K*K channels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  req_      in         valid / ready      feature_sample, weight_sample
//  rsp_      out        valid / ready      out_value, plane_last
//  csr_      in         write enable only  index, write data
//
//  One item is taken every cycle. Each item reads the feature line store and
//  the accumulator plane at acceptance, multiplies in stage 1 and writes the
//  sum back from stage 2, and a group's last channel loads the result register.
//  The rate is set by the single read and single write port of the accumulator
//  plane, which each item uses once. Both stores are left uninitialized by
//  reset; no clearing pass runs. Reset returns the counters, registers and
//  pipeline to their initial state. A stalled result register holds the
//  pipeline, and the input keeps flowing while any stage is free.
//
module shifted_product_channel_sum_unit
   import spcs_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_BITS-1:0]   req_feature_sample,
   input  logic signed [SAMPLE_BITS-1:0]   req_weight_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [OUT_BITS-1:0]      rsp_out_value,
   output logic                            rsp_plane_last,
   input  logic                            csr_we,
   input  csr_index_type                   csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   // Configuration registers.
   logic [KSIZE_BITS-1:0]  cfg_ksize_ff,  cfg_ksize_in;
   logic [DIM_BITS-1:0]    cfg_height_ff, cfg_height_in;
   logic [DIM_BITS-1:0]    cfg_width_ff,  cfg_width_in;
   logic [GCOUNT_BITS-1:0] cfg_groups_ff, cfg_groups_in;

   // Scan counters.
   logic [DIM_BITS-1:0]      col_ff, col_in;
   logic [DIM_BITS-1:0]      row_ff, row_in;
   logic [ACC_ADDR_BITS-1:0] pix_ff, pix_in;
   logic [KOFF_BITS-1:0]     dx_ff, dx_in;
   logic [KOFF_BITS-1:0]     dy_ff, dy_in;
   logic [GRP_BITS-1:0]      grp_ff, grp_in;

   // Clamped settings and derived limits.
   logic [KSIZE_BITS-1:0]  k_side;
   logic [DIM_BITS-1:0]    in_h;
   logic [DIM_BITS-1:0]    in_w;
   logic [GCOUNT_BITS-1:0] groups;
   logic [KOFF_BITS-1:0]   k_last;
   logic [DIM_BITS-1:0]    oh_last;
   logic [DIM_BITS-1:0]    ow_last;
   logic [GRP_BITS-1:0]    g_last;

   // Per-item decode at acceptance.
   logic                    accept;
   logic                    in_plane;
   logic [DIM_BITS-1:0]     row_sh;
   logic [DIM_BITS-1:0]     col_sh;
   logic                    shift_ok;
   logic                    first_k;
   logic                    last_k;
   logic                    col_end;
   logic                    row_end;
   logic                    grp_end;
   logic                    img_end;
   logic [DL_ADDR_BITS-1:0] dl_waddr;
   logic [DL_ADDR_BITS-1:0] dl_raddr;

   // Stores and their registered read data.
   logic signed [SAMPLE_BITS-1:0] dl_mem [DL_DEPTH];
   logic signed [OUT_BITS-1:0]    acc_mem [ACC_DEPTH];
   logic signed [SAMPLE_BITS-1:0] dl_rd_ff;
   logic signed [OUT_BITS-1:0]    acc_rd_ff;

   // Stage 1: read data returns, multiply.
   logic                          s1_v_ff;
   logic signed [SAMPLE_BITS-1:0] s1_f_ff;
   logic signed [SAMPLE_BITS-1:0] s1_wt_ff;
   logic                          s1_sv_ff;
   logic                          s1_fwd_ff;
   logic                          s1_first_ff;
   logic                          s1_emit_ff;
   logic                          s1_last_ff;
   logic                          s1_k1_ff;
   logic [ACC_ADDR_BITS-1:0]      s1_pix_ff;
   logic signed [SAMPLE_BITS-1:0] s1_oper;
   logic signed [PROD_BITS-1:0]   s1_mul;
   logic signed [PROD_BITS-1:0]   s1_prod;

   // Stage 2: accumulate and write back.
   logic                         s2_v_ff;
   logic signed [PROD_BITS-1:0]  s2_prod_ff;
   logic signed [OUT_BITS-1:0]   s2_acc_ff;
   logic                         s2_first_ff;
   logic                         s2_emit_ff;
   logic                         s2_last_ff;
   logic [ACC_ADDR_BITS-1:0]     s2_pix_ff;
   logic signed [OUT_BITS-1:0]   acc_sum;

   // Result register.
   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] rsp_value_ff;
   logic                       rsp_last_ff;

   // Flow control.
   logic out_free;
   logic s2_adv;
   logic s1_adv;

   // Clamp the registers to their legal ranges.
   always_comb begin
      if (cfg_ksize_ff == '0) begin
         k_side = KSIZE_BITS'(1);
      end else if (cfg_ksize_ff > KSIZE_BITS'(MAX_KERNEL)) begin
         k_side = KSIZE_BITS'(MAX_KERNEL);
      end else begin
         k_side = cfg_ksize_ff;
      end
      if (cfg_height_ff == '0) begin
         in_h = DIM_BITS'(1);
      end else if (cfg_height_ff > DIM_BITS'(MAX_OUT_HEIGHT)) begin
         in_h = DIM_BITS'(MAX_OUT_HEIGHT);
      end else begin
         in_h = cfg_height_ff;
      end
      if (cfg_width_ff == '0) begin
         in_w = DIM_BITS'(1);
      end else if (cfg_width_ff > DIM_BITS'(MAX_OUT_WIDTH)) begin
         in_w = DIM_BITS'(MAX_OUT_WIDTH);
      end else begin
         in_w = cfg_width_ff;
      end
      if (cfg_groups_ff == '0) begin
         groups = GCOUNT_BITS'(1);
      end else if (cfg_groups_ff > GCOUNT_BITS'(MAX_GROUPS)) begin
         groups = GCOUNT_BITS'(MAX_GROUPS);
      end else begin
         groups = cfg_groups_ff;
      end
   end

   // Last indexes of the kernel, the enlarged plane and the group count.
   assign k_last  = KOFF_BITS'(k_side - KSIZE_BITS'(1));
   assign oh_last = in_h + DIM_BITS'(k_side) - DIM_BITS'(2);
   assign ow_last = in_w + DIM_BITS'(k_side) - DIM_BITS'(2);
   assign g_last  = GRP_BITS'(groups - GCOUNT_BITS'(1));

   // Decode the current scan position and the channel offset.
   assign accept   = req_valid && req_ready;
   assign in_plane = (row_ff < in_h) && (col_ff < in_w);
   assign row_sh   = row_ff - DIM_BITS'(dy_ff);
   assign col_sh   = col_ff - DIM_BITS'(dx_ff);
   assign shift_ok = (row_ff >= DIM_BITS'(dy_ff)) && (row_sh < in_h) &&
                     (col_ff >= DIM_BITS'(dx_ff)) && (col_sh < in_w);
   assign first_k  = (dx_ff == '0) && (dy_ff == '0);
   assign last_k   = (dx_ff == k_last) && (dy_ff == k_last);
   assign col_end  = (col_ff == ow_last);
   assign row_end  = (row_ff == oh_last);
   assign grp_end  = (grp_ff == g_last);
   assign img_end  = col_end && row_end && last_k && grp_end;
   assign dl_waddr = {row_ff[DL_ROW_BITS-1:0], col_ff[DL_COL_BITS-1:0]};
   assign dl_raddr = {row_sh[DL_ROW_BITS-1:0], col_sh[DL_COL_BITS-1:0]};

   // Pipeline flow: the result register frees stage 2, which frees stage 1.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_v_ff && (!s2_emit_ff || out_free);
   assign s1_adv    = s1_v_ff && (!s2_v_ff || s2_adv);
   assign req_ready = !s1_v_ff || s1_adv;

   // Register writes and scan counter advance; a write restarts the scan.
   always_comb begin
      cfg_ksize_in  = cfg_ksize_ff;
      cfg_height_in = cfg_height_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_groups_in = cfg_groups_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pix_in        = pix_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      grp_in        = grp_ff;
      priority if (csr_we) begin
         unique case (csr_index)
            REG_KERNEL_SIZE: cfg_ksize_in  = csr_wdata[KSIZE_BITS-1:0];
            REG_IN_HEIGHT:   cfg_height_in = csr_wdata[DIM_BITS-1:0];
            REG_IN_WIDTH:    cfg_width_in  = csr_wdata[DIM_BITS-1:0];
            REG_GROUP_COUNT: cfg_groups_in = csr_wdata[GCOUNT_BITS-1:0];
            default:         cfg_ksize_in  = cfg_ksize_ff;
         endcase
         col_in = '0;
         row_in = '0;
         pix_in = '0;
         dx_in  = '0;
         dy_in  = '0;
         grp_in = '0;
      end else if (accept) begin
         if (!col_end) begin
            col_in = col_ff + DIM_BITS'(1);
            pix_in = pix_ff + ACC_ADDR_BITS'(1);
         end else if (!row_end) begin
            col_in = '0;
            row_in = row_ff + DIM_BITS'(1);
            pix_in = pix_ff + ACC_ADDR_BITS'(1);
         end else begin
            // End of a channel plane: step the kernel offset, then the group.
            col_in = '0;
            row_in = '0;
            pix_in = '0;
            if (dx_ff != k_last) begin
               dx_in = dx_ff + KOFF_BITS'(1);
            end else begin
               dx_in = '0;
               if (dy_ff != k_last) begin
                  dy_in = dy_ff + KOFF_BITS'(1);
               end else begin
                  dy_in  = '0;
                  grp_in = grp_end ? '0 : grp_ff + GRP_BITS'(1);
               end
            end
         end
      end else begin
         // No transfer: the scan position holds.
         col_in = col_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ksize_ff  <= KERNEL_RESET;
         cfg_height_ff <= HEIGHT_RESET;
         cfg_width_ff  <= WIDTH_RESET;
         cfg_groups_ff <= GROUP_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         pix_ff        <= '0;
         dx_ff         <= '0;
         dy_ff         <= '0;
         grp_ff        <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ksize_ff  <= cfg_ksize_in;
         cfg_height_ff <= cfg_height_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_groups_ff <= cfg_groups_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pix_ff        <= pix_in;
         dx_ff         <= dx_in;
         dy_ff         <= dy_in;
         grp_ff        <= grp_in;
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_v_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_v_ff <= 1'b0;
         end
         if (s2_adv && s2_emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Feature line store: write inside the input plane, read the shifted entry.
   always_ff @(posedge clock) begin
      if (accept && in_plane) begin
         dl_mem[dl_waddr] <= req_feature_sample;
      end
      if (accept) begin
         dl_rd_ff <= dl_mem[dl_raddr];
      end
   end

   // Accumulator plane: read at acceptance, write back from stage 2.
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         acc_mem[s2_pix_ff] <= acc_sum;
      end
      if (accept) begin
         acc_rd_ff <= acc_mem[pix_ff];
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_f_ff     <= req_feature_sample;
         s1_wt_ff    <= req_weight_sample;
         s1_sv_ff    <= shift_ok;
         s1_fwd_ff   <= first_k;
         s1_first_ff <= first_k;
         s1_emit_ff  <= last_k;
         s1_last_ff  <= img_end;
         s1_k1_ff    <= (k_side == KSIZE_BITS'(1));
         s1_pix_ff   <= pix_ff;
      end
   end

   // A zero offset reads the sample written in the same transfer.
   assign s1_oper = s1_fwd_ff ? s1_f_ff : dl_rd_ff;
   assign s1_mul  = s1_oper * s1_wt_ff;

   // A kernel of one passes the feature through in the sum format.
   always_comb begin
      if (s1_k1_ff) begin
         s1_prod = {{(PROD_BITS-SAMPLE_BITS){s1_f_ff[SAMPLE_BITS-1]}}, s1_f_ff}
                   <<< FRAC_BITS;
      end else if (s1_sv_ff) begin
         s1_prod = s1_mul;
      end else begin
         s1_prod = '0;
      end
   end

   // Stage 2 payload.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_prod_ff  <= s1_prod;
         s2_acc_ff   <= acc_rd_ff;
         s2_first_ff <= s1_first_ff;
         s2_emit_ff  <= s1_emit_ff;
         s2_last_ff  <= s1_last_ff;
         s2_pix_ff   <= s1_pix_ff;
      end
   end

   // The first channel of a group overwrites the stored sum.
   assign acc_sum = (s2_first_ff ? '0 : s2_acc_ff) +
                    {{(OUT_BITS-PROD_BITS){s2_prod_ff[PROD_BITS-1]}}, s2_prod_ff};

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s2_adv && s2_emit_ff) begin
         rsp_value_ff <= acc_sum;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_plane_last = rsp_last_ff;

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !s1_v_ff && !s2_v_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // A sum read in stage 1 never has a write to the same pixel still pending.
   a_acc_hazard: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff && !s1_first_ff |-> s1_pix_ff != s2_pix_ff)
      else $error("accumulator read overlaps a pending write");

   // The pixel address restarts with each plane.
   a_pix_origin: assert property (@(posedge clock) disable iff (reset)
      row_ff == '0 && col_ff == '0 |-> pix_ff == '0)
      else $error("pixel address out of step with the scan");

   // The last transfer of an image returns the scan to its start.
   a_image_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && img_end |=>
         row_ff == '0 && col_ff == '0 && dx_ff == '0 && dy_ff == '0 && grp_ff == '0)
      else $error("scan did not wrap at end of image");

endmodule

@@ verif/tb_shifted_product_channel_sum_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted product channel sum unit: self-checking testbench
// Streams feature and weight samples through the unit under several kernel,
// plane and group settings. A cycle-free predictor of the filter computes the
// expected pixel sums, and every result transfer is compared against them.
// ----------------------------------------------------------------------------
module tb_shifted_product_channel_sum_unit
   import spcs_pkg::*;
();

   localparam int DRAIN_CYCLES   = 10;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] feature;
      logic signed [SAMPLE_BITS-1:0] weight;
   } sample_pair_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] value;
      logic                       last;
   } pixel_sum_type;

   // Block ports; the inputs driven here are known from time zero.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_BITS-1:0]  req_feature_sample = '0;
   logic signed [SAMPLE_BITS-1:0]  req_weight_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0]     rsp_out_value;
   logic                           rsp_plane_last;
   logic                           csr_we = 1'b0;
   csr_index_type                  csr_index = REG_KERNEL_SIZE;
   logic [CSR_DATA_BITS-1:0]       csr_wdata = '0;

   // Stimulus and checking state.
   sample_pair_type sample_queue [$];
   pixel_sum_type   sum_queue [$];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            hold_request = 1'b0;
   int              hold_left = 0;
   logic            req_accepted = 1'b0;
   int              quiet_cycles = 0;
   int              error_count = 0;

   // Predictor copy of the registers, stores and scan position.
   logic [KSIZE_BITS-1:0]          cfg_kernel = KERNEL_RESET;
   logic [DIM_BITS-1:0]            cfg_height = HEIGHT_RESET;
   logic [DIM_BITS-1:0]            cfg_width = WIDTH_RESET;
   logic [GCOUNT_BITS-1:0]         cfg_groups = GROUP_RESET;
   logic signed [SAMPLE_BITS-1:0]  line_store [MAX_KERNEL][MAX_OUT_WIDTH];
   longint                         pixel_sum [ACC_DEPTH];
   int                             row_pos = 0;
   int                             col_pos = 0;
   int                             chan_pos = 0;

   shifted_product_channel_sum_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_feature_sample (req_feature_sample),
      .req_weight_sample  (req_weight_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_value      (rsp_out_value),
      .rsp_plane_last     (rsp_plane_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_to(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // A register write also restarts the scan at channel 0, row 0, column 0.
   function automatic void apply_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_KERNEL_SIZE: cfg_kernel = data[KSIZE_BITS-1:0];
         REG_IN_HEIGHT:   cfg_height = data[DIM_BITS-1:0];
         REG_IN_WIDTH:    cfg_width = data[DIM_BITS-1:0];
         REG_GROUP_COUNT: cfg_groups = data[GCOUNT_BITS-1:0];
         default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
   endfunction

   // Delays the feature by the channel's kernel offset, multiplies it by the
   // weight and sums per pixel over the group; the group's last channel
   // yields the expected pixel sum.
   function automatic void shift_multiply_accumulate(logic signed [SAMPLE_BITS-1:0] feat,
                                                     logic signed [SAMPLE_BITS-1:0] wgt);
      int            ks, ih, iw, oh, ow, kk, chans, k, dy, dx, addr;
      longint        term;
      pixel_sum_type res;
      ks = clamp_to(cfg_kernel, 1, MAX_KERNEL);
      ih = clamp_to(cfg_height, 1, MAX_OUT_HEIGHT);
      iw = clamp_to(cfg_width, 1, MAX_OUT_WIDTH);
      oh = ih + ks - 1;
      ow = iw + ks - 1;
      kk = ks * ks;
      chans = clamp_to(cfg_groups, 1, MAX_GROUPS) * kk;
      term = 0;
      if (row_pos >= oh || col_pos >= ow || chan_pos >= chans) begin
         row_pos = 0;
         col_pos = 0;
         chan_pos = 0;
      end

      // Only positions inside the original plane enter the line store.
      if (row_pos < ih && col_pos < iw) begin
         line_store[row_pos % MAX_KERNEL][col_pos] = feat;
      end
      k = chan_pos % kk;
      dy = k / ks;
      dx = k % ks;
      if (row_pos >= dy && row_pos - dy < ih && col_pos >= dx && col_pos - dx < iw) begin
         term = longint'(line_store[(row_pos - dy) % MAX_KERNEL][col_pos - dx]) * longint'(wgt);
      end

      // The group's first channel overwrites the pixel sum, later ones add.
      addr = row_pos * ACC_COLS + col_pos;
      if (k == 0) begin
         pixel_sum[addr] = term;
      end else begin
         pixel_sum[addr] = pixel_sum[addr] + term;
      end
      if (k == kk - 1) begin
         res.value = (ks == 1) ? OUT_BITS'(longint'(feat) <<< FRAC_BITS)
                               : OUT_BITS'(pixel_sum[addr]);
         res.last = (chan_pos == chans - 1 && row_pos == oh - 1 && col_pos == ow - 1);
         sum_queue.push_back(res);
      end

      // Raster scan within the channel, then the next channel, then wrap.
      col_pos = col_pos + 1;
      if (col_pos >= ow) begin
         col_pos = 0;
         row_pos = row_pos + 1;
         if (row_pos >= oh) begin
            row_pos = 0;
            chan_pos = chan_pos + 1;
            if (chan_pos >= chans) begin
               chan_pos = 0;
            end
         end
      end
   endfunction

   // Mostly full-range values, with the corners of the Q8.8 range mixed in.
   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic queue_pair(logic [SAMPLE_BITS-1:0] feat, logic [SAMPLE_BITS-1:0] wgt);
      sample_pair_type item;
      item.feature = feat;
      item.weight = wgt;
      sample_queue.push_back(item);
   endtask

   // Waits at rising edges, where the offered sample is settled, until every
   // sample is transferred and every sum has come back, then lets the
   // pipeline empty of items without a result.
   task automatic wait_for_drain();
      while (sample_queue.size() != 0 || req_valid || sum_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Back-to-back register writes; called at a falling edge.
   task automatic write_register(csr_index_type idx, int data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(data);
      @(negedge clock);
   endtask

   task automatic program_filter(int kernel, int height, int width, int groups);
      write_register(REG_KERNEL_SIZE, kernel);
      write_register(REG_IN_HEIGHT, height);
      write_register(REG_IN_WIDTH, width);
      write_register(REG_GROUP_COUNT, groups);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(int kernel, int height, int width, int groups, int count,
                            int send_pct, int recv_pct);
      wait_for_drain();
      program_filter(kernel, height, width, groups);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) queue_pair(random_sample(), random_sample());
   endtask

   // Sample driver: offers the next pending pair once the previous one has
   // been transferred, with random gaps.
   always @(negedge clock) begin : drive_samples
      sample_pair_type item;
      if (!req_valid || req_accepted) begin
         if (!reset && sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_feature_sample <= item.feature;
            req_weight_sample <= item.weight;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin : drive_ready
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: follows register writes and sample transfers in the predictor,
   // checks each result transfer and watches for a stuck pipeline.
   always @(posedge clock) begin : observe
      pixel_sum_type want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         if (csr_we) begin
            apply_register(csr_index, csr_wdata);
         end
         if (req_accepted) begin
            shift_multiply_accumulate(req_feature_sample, req_weight_sample);
         end
         if (rsp_valid && rsp_ready) begin
            if (sum_queue.size() == 0) begin
               $error("out_value: unexpected result, expected none, actual %0d",
                      rsp_out_value);
               error_count++;
            end else begin
               want = sum_queue.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value mismatch: expected %0d, actual %0d",
                         want.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_plane_last !== want.last) begin
                  $error("plane_last mismatch: expected %0b, actual %0b",
                         want.last, rsp_plane_last);
                  error_count++;
               end
            end
         end

         if (req_accepted || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int i;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: a partial first channel, cut short by the next write.
      queue_pair({1'b0, {(SAMPLE_BITS-1){1'b1}}}, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
      queue_pair({1'b1, {(SAMPLE_BITS-1){1'b0}}}, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
      queue_pair({1'b1, {(SAMPLE_BITS-1){1'b0}}}, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
      queue_pair('0, '1);

      // Kernel size zero saturates to one: features pass straight through.
      wait_for_drain();
      program_filter(0, 1, 2, 2);
      queue_pair({1'b0, {(SAMPLE_BITS-1){1'b1}}}, random_sample());
      queue_pair({1'b1, {(SAMPLE_BITS-1){1'b0}}}, random_sample());
      queue_pair('0, random_sample());
      queue_pair('1, random_sample());

      // Two by two kernel over one pixel: full-scale operands in every pair.
      wait_for_drain();
      program_filter(2, 1, 1, 1);
      for (i = 0; i < 16; i++) begin
         queue_pair((i % 3 == 0) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                 : {1'b1, {(SAMPLE_BITS-1){1'b0}}},
                    (i % 2 == 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                 : {1'b1, {(SAMPLE_BITS-1){1'b0}}});
      end

      // Random content over small complete images and partial large ones.
      run_phase(1, 0, 3, 3, 40, 0, 0);
      run_phase(2, 2, 2, 2, 72, 59, 0);
      run_phase(3, 2, 2, 1, 144, 0, 59);
      run_phase(4, 1, 1, 1, 256, 12, 12);
      run_phase(5, 1, 2, 1, 320, 0, 0);
      run_phase(2, 3, 0, 2047, 64, 59, 0);
      run_phase(4, 1, 256, 1, 40, 0, 59);
      run_phase(0, 1, 1, 1, 30, 12, 12);
      run_phase(3, 1, 1, 2, 162, 59, 0);
      run_phase(1, 1, 400, 1, 50, 0, 59);

      // Receiver holds off for a long stretch while samples keep coming.
      wait_for_drain();
      program_filter(1, 511, 1, 1024);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      repeat (200) queue_pair(random_sample(), random_sample());

      wait_for_drain();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
